// ===== hdl/kmp_pkg.sv =====
// shared types, sizes and codes for the kmp stream matcher
package kmp_pkg;

  localparam int MAX_PATTERN   = 64;
  localparam int POSITION_BITS = 32;
  localparam int LEN_BITS      = $clog2(MAX_PATTERN + 1);
  localparam int IDX_BITS      = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int START_BITS    = (POSITION_BITS > 32) ? POSITION_BITS : 32;

  // request type codes
  localparam logic [1:0] REQ_CLEAR   = 2'd0;
  localparam logic [1:0] REQ_APPEND  = 2'd1;
  localparam logic [1:0] REQ_TEXT    = 2'd2;
  localparam logic [1:0] REQ_RESTART = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_BAD   = 2'd3;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] byte_value;
  } req_t;

  typedef struct packed {
    logic        match_found;
    logic [31:0] match_start;
    logic [1:0]  status;
  } rsp_t;

  // classified work item handed from the front to the engine
  typedef struct packed {
    logic       clear_all;
    logic       restart;
    logic       append;
    logic       text;
    logic [7:0] byte_value;
  } work_t;

endpackage

// ===== hdl/kmp_front.sv =====
// front end: accepts request beats, classifies them and queues them for the engine
module kmp_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  kmp_pkg::req_t  req,
  output logic           work_valid,
  output kmp_pkg::work_t work,
  input  logic           work_pop
);

  kmp_pkg::work_t slots [2];
  kmp_pkg::work_t cls;
  logic [1:0]     count;
  logic           wr_ptr;
  logic           rd_ptr;
  logic           push_ok;
  logic           pop_ok;

  // decode the request type into one flag per kind of work
  always_comb begin
    cls            = '0;
    cls.byte_value = req.byte_value;
    unique case (req.req_type)
      kmp_pkg::REQ_CLEAR:   cls.clear_all = 1'b1;
      kmp_pkg::REQ_APPEND:  cls.append    = 1'b1;
      kmp_pkg::REQ_TEXT:    cls.text      = 1'b1;
      kmp_pkg::REQ_RESTART: cls.restart   = 1'b1;
      default:              cls.restart   = 1'b1;
    endcase
  end

  assign full       = (count == 2'd2);
  assign work_valid = (count != 2'd0);
  assign work       = slots[rd_ptr];
  assign push_ok    = push && !full;
  assign pop_ok     = work_pop && work_valid;

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push_ok) wr_ptr <= ~wr_ptr;
      if (pop_ok)  rd_ptr <= ~rd_ptr;
      if (push_ok && !pop_ok)      count <= count + 2'd1;
      else if (pop_ok && !push_ok) count <= count - 2'd1;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push_ok) slots[wr_ptr] <= cls;
  end

endmodule

// ===== hdl/kmp_engine.sv =====
// back end: pattern build and text matching by failure link walks over the pattern memories
module kmp_engine (
  input  logic           clk,
  input  logic           rst,
  input  logic           work_valid,
  input  kmp_pkg::work_t work,
  output logic           work_pop,
  input  logic           res_full,
  output logic           res_push,
  output kmp_pkg::rsp_t  res
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  localparam logic [kmp_pkg::LEN_BITS-1:0] MAX_LEN =
    kmp_pkg::LEN_BITS'(kmp_pkg::MAX_PATTERN);
  localparam logic [kmp_pkg::LEN_BITS-1:0] LEN_ONE = kmp_pkg::LEN_BITS'(1);
  localparam logic [kmp_pkg::POSITION_BITS-1:0] POS_ONE =
    kmp_pkg::POSITION_BITS'(1);

  logic [1:0] state, state_next;
  kmp_pkg::work_t op, op_next;

  logic [kmp_pkg::LEN_BITS-1:0] len, len_next;
  logic [kmp_pkg::LEN_BITS-1:0] bpl, bpl_next;
  logic [kmp_pkg::LEN_BITS-1:0] matched, matched_next;
  logic [kmp_pkg::LEN_BITS-1:0] cur, cur_next;
  logic [kmp_pkg::LEN_BITS-1:0] rd_addr;
  logic [kmp_pkg::POSITION_BITS-1:0] pos, pos_next;

  logic [7:0]                   pattern_mem [kmp_pkg::MAX_PATTERN];
  logic [kmp_pkg::LEN_BITS-1:0] link_mem    [kmp_pkg::MAX_PATTERN + 1];
  logic [7:0]                   p_rd;
  logic [kmp_pkg::LEN_BITS-1:0] f_rd;
  logic [kmp_pkg::IDX_BITS-1:0] p_raddr;

  logic                              mem_we;
  logic [kmp_pkg::LEN_BITS-1:0]      link_wval;
  logic                              walk_more;
  logic                              pat_full;
  logic                              pos_sat;
  logic [kmp_pkg::POSITION_BITS-1:0] start_pos;
  logic [kmp_pkg::START_BITS-1:0]    start_wide;

  // sequencer: take a work beat, walk failure links one per cycle, emit one result
  always_comb begin
    state_next   = state;
    op_next      = op;
    len_next     = len;
    bpl_next     = bpl;
    matched_next = matched;
    cur_next     = cur;
    pos_next     = pos;
    rd_addr      = cur;
    work_pop     = 1'b0;
    res_push     = 1'b0;
    res          = '0;
    mem_we       = 1'b0;

    pat_full   = (len >= MAX_LEN);
    pos_sat    = (pos == '1);
    walk_more  = (cur != '0) && ((cur >= len) || (p_rd != op.byte_value));
    start_pos  = pos - kmp_pkg::POSITION_BITS'(len) + POS_ONE;
    start_wide = kmp_pkg::START_BITS'(start_pos);
    link_wval  = (len == '0) ? '0 : cur;

    unique case (state)
      S_IDLE: begin
        if (work_valid) begin
          work_pop   = 1'b1;
          op_next    = work;
          state_next = S_EMIT;
          if (work.append && !pat_full && (len != '0)) begin
            cur_next   = bpl;
            rd_addr    = bpl;
            state_next = S_CMP;
          end else if (work.text && (len != '0)) begin
            cur_next   = matched;
            rd_addr    = matched;
            state_next = S_CMP;
          end
        end
      end
      S_CMP: begin
        if (walk_more) begin
          cur_next = f_rd;
          rd_addr  = f_rd;
        end else begin
          if ((cur < len) && (p_rd == op.byte_value)) cur_next = cur + LEN_ONE;
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!res_full) begin
          res_push   = 1'b1;
          state_next = S_IDLE;
          if (op.clear_all) begin
            len_next     = '0;
            bpl_next     = '0;
            matched_next = '0;
            pos_next     = '0;
          end else if (op.restart) begin
            matched_next = '0;
            pos_next     = '0;
          end else if (op.append) begin
            if (pat_full) begin
              res.status = kmp_pkg::ST_FULL;
            end else begin
              mem_we   = 1'b1;
              bpl_next = link_wval;
              len_next = len + LEN_ONE;
            end
          end else begin
            if (!pos_sat) pos_next = pos + POS_ONE;
            if (len == '0) begin
              res.status = kmp_pkg::ST_EMPTY;
            end else begin
              matched_next = cur;
              if (cur == len) begin
                res.match_found = 1'b1;
                res.match_start = start_wide[31:0];
              end
            end
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control and match state
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      len     <= '0;
      bpl     <= '0;
      matched <= '0;
      pos     <= '0;
    end else begin
      state   <= state_next;
      len     <= len_next;
      bpl     <= bpl_next;
      matched <= matched_next;
      pos     <= pos_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    op  <= op_next;
    cur <= cur_next;
  end

  // pattern and link memories, registered reads
  assign p_raddr = (rd_addr < MAX_LEN) ? rd_addr[kmp_pkg::IDX_BITS-1:0] : '0;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      pattern_mem[len[kmp_pkg::IDX_BITS-1:0]] <= op.byte_value;
      link_mem[len + LEN_ONE]                 <= link_wval;
    end
    p_rd <= pattern_mem[p_raddr];
    f_rd <= link_mem[rd_addr];
  end

endmodule

// ===== hdl/kmp_result_fifo.sv =====
// two-entry result queue between the engine and the result port
module kmp_result_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_push,
  input  kmp_pkg::rsp_t wr_data,
  output logic          wr_full,
  output logic          empty,
  input  logic          pop,
  output kmp_pkg::rsp_t rsp
);

  kmp_pkg::rsp_t slots [2];
  logic [1:0]    count;
  logic          wr_ptr;
  logic          rd_ptr;
  logic          push_ok;
  logic          pop_ok;

  assign wr_full = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign rsp     = slots[rd_ptr];
  assign push_ok = wr_push && !wr_full;
  assign pop_ok  = pop && !empty;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push_ok) wr_ptr <= ~wr_ptr;
      if (pop_ok)  rd_ptr <= ~rd_ptr;
      if (push_ok && !pop_ok)      count <= count + 2'd1;
      else if (pop_ok && !push_ok) count <= count - 2'd1;
    end
  end

  // result storage
  always_ff @(posedge clk) begin
    if (push_ok) slots[wr_ptr] <= wr_data;
  end

endmodule

// ===== hdl/kmp_stream_matcher_top.sv =====
// top level of the kmp stream matcher
// Request channel: push/full with req (req_type, byte_value). A beat is taken
// when push is high and full is low. Types: clear all, append pattern byte,
// text byte, restart text. Every request beat yields exactly one result beat.
// Result channel: empty/pop with rsp (match_found, match_start, status). The
// oldest result sits on rsp while empty is low and leaves when pop is high.
// Flow: clear, restart, a dropped pattern byte, the first pattern byte and
// text with an empty pattern go straight from the taken beat to the result;
// any other append or text byte first walks failure links until the byte
// compares equal or the walk reaches the start of the pattern. The engine
// reads the pattern and link memories once per cycle; over a text stream it
// follows at most about one failure link per byte on average. It takes a
// new request only after its result has gone to the result queue. Two-entry
// queues on both sides let requests be taken while results wait; when pop
// stays low the result queue fills, the engine holds its finished result
// and the request queue then raises full.
// Reset (rst, synchronous): empties both queues and clears pattern length,
// border length, match length and text position; memory contents are kept.
module kmp_stream_matcher_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  kmp_pkg::req_t req,
  output logic          empty,
  input  logic          pop,
  output kmp_pkg::rsp_t rsp
);

  logic           work_valid;
  logic           work_pop;
  kmp_pkg::work_t work;
  logic           res_full;
  logic           res_push;
  kmp_pkg::rsp_t  res;

  // request intake and classification
  kmp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .req        (req),
    .work_valid (work_valid),
    .work       (work),
    .work_pop   (work_pop)
  );

  // matching engine
  kmp_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .work_valid (work_valid),
    .work       (work),
    .work_pop   (work_pop),
    .res_full   (res_full),
    .res_push   (res_push),
    .res        (res)
  );

  // result queue
  kmp_result_fifo u_result (
    .clk     (clk),
    .rst     (rst),
    .wr_push (res_push),
    .wr_data (res),
    .wr_full (res_full),
    .empty   (empty),
    .pop     (pop),
    .rsp     (rsp)
  );

endmodule

// ===== hdl/kmp_chk.sv =====
// port-level checker for the kmp stream matcher, bound to the top level
module kmp_chk (
  input logic          clk,
  input logic          rst,
  input logic          full,
  input logic          empty,
  input logic          pop,
  input kmp_pkg::rsp_t rsp
);

  // reset leaves no result waiting
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  // reset leaves room for requests
  a_reset_room: assert property (@(posedge clk) rst |=> !full)
    else $error("request queue full after reset");

  // a waiting result that is not taken stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(rsp)))
    else $error("stalled result beat changed");

  // a match always reports ok status
  a_match_ok: assert property (@(posedge clk) disable iff (rst)
    (!empty && rsp.match_found) |-> (rsp.status == kmp_pkg::ST_OK))
    else $error("match with non-ok status");

  // no match means zero start and a known status
  a_nomatch: assert property (@(posedge clk) disable iff (rst)
    (!empty && !rsp.match_found) |->
      ((rsp.match_start == 32'd0) && (rsp.status != kmp_pkg::ST_BAD)))
    else $error("bad fields on a result without match");

endmodule

bind kmp_stream_matcher_top kmp_chk u_chk (
  .clk   (clk),
  .rst   (rst),
  .full  (full),
  .empty (empty),
  .pop   (pop),
  .rsp   (rsp)
);
